[src/lge_pkg.sv]
`timescale 1ns / 1ps

package lge_pkg;

  // Store depth of one cell bank
  localparam int unsigned GridCellsDefault = 65536;

  // Item function codes
  localparam logic [1:0] FuncLoad = 2'd0;
  localparam logic [1:0] FuncRead = 2'd1;
  localparam logic [1:0] FuncStep = 2'd2;

  // Configuration port geometry and register indexes
  localparam int unsigned PaddrWidth = 4;
  localparam int unsigned PdataWidth = 32;
  localparam logic [1:0] RegGridWidth  = 2'd0;
  localparam logic [1:0] RegGridHeight = 2'd1;
  localparam logic [1:0] RegWrapEdges  = 2'd2;

  // Register reset values
  localparam logic [7:0] GridWidthReset  = 8'd100;
  localparam logic [7:0] GridHeightReset = 8'd40;

  // B3/S23: survive on two or three neighbours, birth on exactly three
  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    logic survive;
    logic birth;
    survive = (count == 4'd2) || (count == 4'd3);
    birth   = (count == 4'd3);
    return alive ? survive : birth;
  endfunction

endpackage

[src/life_generation_engine.sv]
`timescale 1ns / 1ps

// Conway Life (B3/S23) engine over two one-bit cell banks held in a single
// memory with one read and one write port. A load passes from idle to the
// finish state, a read through the read-cell and read-out states first. A
// generation step visits each of the min(grid_width * grid_height, GRID_CELLS)
// cells in address order; each cell has a start state, nine neighbourhood taps
// read one by one on the single read port (each via address, read and
// accumulate states) and a write-back. The block takes no new item while one
// is in work; a finished result waits in the output register without blocking
// the next accept. Bank contents are undefined after reset until written.
module life_generation_engine #(
  parameter int unsigned GRID_CELLS = lge_pkg::GridCellsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lge_pkg::PaddrWidth-1:0]  paddr,
  input  logic [lge_pkg::PdataWidth-1:0]  pwdata,
  output logic [lge_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic [15:0]                     cell_index,
  input  logic                            cell_value,
  // output channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            read_value,
  output logic                            converged
);

  import lge_pkg::*;

  localparam int unsigned AW       = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int unsigned CW       = $clog2(GRID_CELLS + 1);
  localparam int unsigned MemDepth = 2 ** (AW + 1);
  localparam logic [16:0] CellsW   = 17'(GRID_CELLS);

  // Neighbourhood offset codes
  localparam logic [1:0] OffMinus = 2'd0;
  localparam logic [1:0] OffZero  = 2'd1;
  localparam logic [1:0] OffPlus  = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RDCELL = 10'b0000000010,
    S_RDOUT  = 10'b0000000100,
    S_SIZE   = 10'b0000001000,
    S_CELL   = 10'b0000010000,
    S_CALC   = 10'b0000100000,
    S_READ   = 10'b0001000000,
    S_ACC    = 10'b0010000000,
    S_WRITE  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [7:0] grid_width;
  logic [7:0] grid_height;
  logic       wrap_edges;
  logic       active_bank;

  // sequencer registers
  logic [15:0]   idx;
  logic [CW-1:0] size;
  logic [CW-1:0] visit;
  logic [7:0]    row;
  logic [7:0]    col;
  logic [1:0]    kr;
  logic [1:0]    kc;
  logic [3:0]    count;
  logic          old;
  logic          same;
  logic [15:0]   tap_addr;
  logic          tap_use;
  logic          tap_centre;
  logic          res_read;
  logic          res_conv;

  // memory
  logic          mem [MemDepth];
  logic          rd_data;
  logic [AW:0]   raddr;
  logic [AW:0]   waddr;
  logic          wdata;
  logic          wen;

  // tap address unit
  logic [7:0]    h_last;
  logic [7:0]    w_last;
  logic [7:0]    nr;
  logic [7:0]    nc;
  logic          row_ok;
  logic          col_ok;
  logic [15:0]   tap_addr_next;
  logic          tap_use_next;
  logic [15:0]   prod;
  logic          next_alive;
  logic          accept;
  logic          out_free;
  logic          cfg_write;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite;
  assign h_last     = grid_height - 8'd1;
  assign w_last     = grid_width - 8'd1;
  assign prod       = 16'(grid_width) * 16'(grid_height);
  assign next_alive = life_rule(old, count);

  // Return register contents
  always_comb begin
    case (paddr[3:2])
      RegGridWidth:  prdata = PdataWidth'(grid_width);
      RegGridHeight: prdata = PdataWidth'(grid_height);
      RegWrapEdges:  prdata = PdataWidth'(wrap_edges);
      default:       prdata = '0;
    endcase
  end

  // Map the current offset to a row and column, dead border or torus
  always_comb begin
    case (kr)
      OffMinus: begin
        row_ok = (row != 8'd0) || wrap_edges;
        nr     = (row == 8'd0) ? h_last : row - 8'd1;
      end
      OffZero: begin
        row_ok = 1'b1;
        nr     = row;
      end
      default: begin
        row_ok = (row != h_last) || wrap_edges;
        nr     = (row == h_last) ? 8'd0 : row + 8'd1;
      end
    endcase
    case (kc)
      OffMinus: begin
        col_ok = (col != 8'd0) || wrap_edges;
        nc     = (col == 8'd0) ? w_last : col - 8'd1;
      end
      OffZero: begin
        col_ok = 1'b1;
        nc     = col;
      end
      default: begin
        col_ok = (col != w_last) || wrap_edges;
        nc     = (col == w_last) ? 8'd0 : col + 8'd1;
      end
    endcase
    tap_addr_next = 16'(nr) * 16'(grid_width) + 16'(nc);
    tap_use_next  = row_ok && col_ok && !((nr == row) && (nc == col)) &&
                    ({1'b0, tap_addr_next} < CellsW);
  end

  // Select memory ports
  always_comb begin
    if (state == S_RDCELL) begin
      raddr = {active_bank, idx[AW-1:0]};
    end else begin
      raddr = {active_bank, tap_addr[AW-1:0]};
    end
    if (state == S_WRITE) begin
      waddr = {~active_bank, visit[AW-1:0]};
      wdata = next_alive;
      wen   = 1'b1;
    end else begin
      waddr = {active_bank, cell_index[AW-1:0]};
      wdata = cell_value;
      wen   = accept && (func == FuncLoad) && ({1'b0, cell_index} < CellsW);
    end
  end

  // Cell memory: both banks, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Sequence the item
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FuncRead: state_next = S_RDCELL;
            FuncStep: state_next = S_SIZE;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_RDCELL: state_next = S_RDOUT;
      S_RDOUT:  state_next = S_FINISH;
      S_SIZE:   state_next = S_CELL;
      S_CELL:   state_next = (visit == size) ? S_FINISH : S_CALC;
      S_CALC:   state_next = S_READ;
      S_READ:   state_next = S_ACC;
      S_ACC:    state_next = (kr == OffPlus && kc == OffPlus) ? S_WRITE : S_CALC;
      S_WRITE:  state_next = S_CELL;
      S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
      default:  state_next = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      grid_width  <= GridWidthReset;
      grid_height <= GridHeightReset;
      wrap_edges  <= 1'b0;
      active_bank <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (paddr[3:2])
          RegGridWidth:  grid_width  <= pwdata[7:0];
          RegGridHeight: grid_height <= pwdata[7:0];
          RegWrapEdges:  wrap_edges  <= pwdata[0];
          default: ;
        endcase
      end
      if (state == S_CELL && visit == size) begin
        active_bank <= ~active_bank;
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx      <= cell_index;
        res_read <= 1'b0;
        res_conv <= 1'b0;
      end
      S_RDOUT: begin
        res_read <= ({1'b0, idx} < CellsW) ? rd_data : 1'b0;
      end
      S_SIZE: begin
        size  <= ({1'b0, prod} >= CellsW) ? CW'(GRID_CELLS) : CW'(prod);
        visit <= '0;
        row   <= '0;
        col   <= '0;
        same  <= 1'b1;
      end
      S_CELL: begin
        kr       <= OffMinus;
        kc       <= OffMinus;
        count    <= '0;
        old      <= 1'b0;
        res_conv <= same;
      end
      S_CALC: begin
        tap_addr   <= tap_addr_next;
        tap_use    <= tap_use_next;
        tap_centre <= (kr == OffZero) && (kc == OffZero);
      end
      S_ACC: begin
        if (tap_use && rd_data) begin
          count <= count + 4'd1;
        end
        if (tap_centre) begin
          old <= rd_data;
        end
        if (kc == OffPlus) begin
          kc <= OffMinus;
          kr <= kr + 2'd1;
        end else begin
          kc <= kc + 2'd1;
        end
      end
      S_WRITE: begin
        if (next_alive != old) begin
          same <= 1'b0;
        end
        visit <= visit + CW'(1);
        if (col == w_last) begin
          col <= '0;
          row <= row + 8'd1;
        end else begin
          col <= col + 8'd1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          read_value <= res_read;
          converged  <= res_conv;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/lge_checker.sv]
`timescale 1ns / 1ps

module lge_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic read_value,
  input logic converged
);

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(converged))
    else $error("stalled result changed");

  // Stay busy in the cycle after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after accept");

  // Report only one kind of result per transaction
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_value && converged))
    else $error("read and step result together");

  // Raise a result only out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind life_generation_engine lge_checker u_lge_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_value (read_value),
  .converged  (converged)
);

[sim/tb_life_generation_engine.sv]
`timescale 1ns / 1ps

// One result per transaction: the read cell, or the convergence flag of a step
typedef struct packed {
  logic read_value;
  logic converged;
} life_outcome_t;

class life_scoreboard;
  // Mirror of both banks, plus a record of which cells have been written
  bit cells [0:1][0:65535];
  bit written [0:1][0:65535];
  bit bank;
  int unsigned width;
  int unsigned height;
  bit wrap;
  life_outcome_t awaited_results[$];
  int unsigned failures;

  function new();
    bank = 1'b0;
    width = {24'd0, lge_pkg::GridWidthReset};
    height = {24'd0, lge_pkg::GridHeightReset};
    wrap = 1'b0;
    failures = 0;
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      lge_pkg::RegGridWidth: width = {24'd0, value[7:0]};
      lge_pkg::RegGridHeight: height = {24'd0, value[7:0]};
      lge_pkg::RegWrapEdges: wrap = value[0];
      default: ;
    endcase
  endfunction

  function int unsigned region_size();
    return width * height;
  endfunction

  function bit is_written(logic [15:0] addr);
    return written[bank][addr];
  endfunction

  function int unsigned pending();
    return awaited_results.size();
  endfunction

  // Count live cells around (r0, c0); on a torus each offset is mapped on its own
  function int unsigned live_neighbours(int r0, int c0);
    int w;
    int h;
    int rb;
    int re;
    int cb;
    int ce;
    int r;
    int c;
    int nr;
    int nc;
    int unsigned n;
    w = width;
    h = height;
    rb = (r0 > 0 || wrap) ? r0 - 1 : r0;
    cb = (c0 > 0 || wrap) ? c0 - 1 : c0;
    re = (r0 < h - 1 || wrap) ? r0 + 1 : r0;
    ce = (c0 < w - 1 || wrap) ? c0 + 1 : c0;
    n = 0;
    for (r = rb; r <= re; r++) begin
      nr = (r == -1) ? h - 1 : (r == h) ? 0 : r;
      for (c = cb; c <= ce; c++) begin
        nc = (c == -1) ? w - 1 : (c == w) ? 0 : c;
        if (nr == r0 && nc == c0) continue;
        if (cells[bank][nr * w + nc]) n++;
      end
    end
    return n;
  endfunction

  // Compute the next generation into the idle bank and swap banks
  function bit advance_generation();
    int unsigned size;
    int unsigned i;
    int unsigned n;
    bit alive;
    bit fresh;
    bit same;
    size = width * height;
    same = 1'b1;
    for (i = 0; i < size; i++) begin
      alive = cells[bank][i];
      n = live_neighbours(int'(i / width), int'(i % width));
      fresh = alive ? (n == 2 || n == 3) : (n == 3);
      if (fresh != alive) same = 1'b0;
      cells[!bank][i] = fresh;
      written[!bank][i] = 1'b1;
    end
    bank = !bank;
    return same;
  endfunction

  // Note an accepted input transaction and queue its outcome
  function void note_item(logic [1:0] op, logic [15:0] idx, logic v);
    life_outcome_t o;
    o = '0;
    case (op)
      lge_pkg::FuncLoad: begin
        cells[bank][idx] = v;
        written[bank][idx] = 1'b1;
      end
      lge_pkg::FuncRead: o.read_value = cells[bank][idx];
      lge_pkg::FuncStep: o.converged = advance_generation();
      default: ;
    endcase
    awaited_results.push_back(o);
  endfunction

  // Compare a result transaction against the oldest outcome waiting
  function void check_result(logic rv, logic cv);
    life_outcome_t o;
    if (awaited_results.size() == 0) begin
      $error("result transaction with no outcome waiting");
      failures++;
      return;
    end
    o = awaited_results.pop_front();
    if (rv !== o.read_value) begin
      $error("read_value: expected %0d, got %0d", o.read_value, rv);
      failures++;
    end
    if (cv !== o.converged) begin
      $error("converged: expected %0d, got %0d", o.converged, cv);
      failures++;
    end
  endfunction
endclass

module tb_life_generation_engine;
  import lge_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned CycleLimit = 2000000;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrWidth-1:0] paddr = '0;
  logic [PdataWidth-1:0] pwdata = '0;
  logic [PdataWidth-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FuncLoad;
  logic [15:0] cell_index = '0;
  logic cell_value = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic read_value;
  logic converged;

  life_scoreboard board;
  bit steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles;
  logic [15:0] far_cells[$];

  life_generation_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .cell_index(cell_index),
    .cell_value(cell_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_value(read_value),
    .converged (converged)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random and check every accepted result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 23);
      if (out_valid && out_ready) board.check_result(read_value, converged);
    end
  end

  // Present one input transaction, with an optional random gap, and hold it until taken
  task automatic push_item(logic [1:0] op, logic [15:0] idx, logic v);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    cell_index <= idx;
    cell_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_item(op, idx, v);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
  endtask

  // Program the grid geometry; call only with the block idle
  task automatic configure(int unsigned w, int unsigned h, bit wr);
    write_reg(RegGridWidth, w);
    write_reg(RegGridHeight, h);
    write_reg(RegWrapEdges, 32'(wr));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Load every cell of the grid with live cells at the given percentage
  task automatic fill_grid(int unsigned density);
    int unsigned i;
    for (i = 0; i < board.region_size(); i++) begin
      push_item(FuncLoad, 16'(i), $urandom_range(99) < density);
    end
  endtask

  // Issue one random transaction that never reads an unwritten cell
  task automatic random_op();
    int unsigned roll;
    int unsigned size;
    logic [15:0] idx;
    roll = $urandom_range(99);
    size = board.region_size();
    if (roll < 25) begin
      push_item(FuncStep, 16'($urandom_range(65535)), 1'($urandom_range(1)));
    end else if (roll < 60) begin
      if (far_cells.size() != 0 && $urandom_range(1) == 1) begin
        idx = far_cells[$urandom_range(far_cells.size() - 1)];
      end else begin
        idx = 16'($urandom_range(size - 1));
      end
      if (!board.is_written(idx)) idx = 16'($urandom_range(size - 1));
      push_item(FuncRead, idx, 1'($urandom_range(1)));
    end else if (roll < 90) begin
      if ($urandom_range(1) == 1) begin
        idx = 16'($urandom_range(65535));
        far_cells.push_back(idx);
      end else begin
        idx = 16'($urandom_range(size - 1));
      end
      push_item(FuncLoad, idx, 1'($urandom_range(1)));
    end else begin
      push_item(FuncUnused, 16'($urandom_range(65535)), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, bit wr, int unsigned density,
                           int unsigned ops);
    configure(w, h, wr);
    fill_grid(density);
    repeat (ops) random_op();
    drain();
  endtask

  // Bound the run
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned mark;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: extreme addresses and an unknown function code
    push_item(FuncLoad, 16'h0000, 1'b1);
    push_item(FuncLoad, 16'hFFFF, 1'b1);
    push_item(FuncLoad, 16'h5555, 1'b0);
    push_item(FuncLoad, 16'hAAAA, 1'b1);
    push_item(FuncRead, 16'hFFFF, 1'b0);
    push_item(FuncRead, 16'hAAAA, 1'b1);
    push_item(FuncRead, 16'h0000, 1'b0);
    push_item(FuncRead, 16'h5555, 1'b1);
    push_item(FuncUnused, 16'hFFFF, 1'b1);
    push_item(FuncRead, 16'hFFFF, 1'b0);
    drain();

    // Single-cell torus: every offset folds onto the centre itself
    configure(1, 1, 1'b1);
    push_item(FuncLoad, 16'd0, 1'b1);
    push_item(FuncStep, 16'd0, 1'b0);
    push_item(FuncRead, 16'd0, 1'b0);
    drain();

    // Two by two torus: neighbours counted more than once
    configure(2, 2, 1'b1);
    push_item(FuncLoad, 16'd0, 1'b1);
    push_item(FuncLoad, 16'd1, 1'b1);
    push_item(FuncLoad, 16'd2, 1'b0);
    push_item(FuncLoad, 16'd3, 1'b0);
    push_item(FuncStep, 16'd0, 1'b0);
    push_item(FuncRead, 16'd2, 1'b0);
    drain();

    // Empty grids: nothing visited, still converged, banks still swap
    configure(0, 2, 1'b0);
    push_item(FuncStep, 16'd0, 1'b0);
    push_item(FuncRead, 16'd0, 1'b0);
    drain();
    configure(3, 0, 1'b1);
    push_item(FuncStep, 16'd0, 1'b0);
    push_item(FuncRead, 16'd0, 1'b0);
    drain();

    // Single-row and single-column strips, the first with no idling on either side
    steady = 1'b1;
    run_phase(24, 1, 1'($urandom_range(1)), 40, 8);
    steady = 1'b0;
    run_phase(1, 24, 1'b1, 35, 8);

    // Small random grids with random contents
    mark = items_sent;
    while (items_sent - mark < 20) begin
      run_phase($urandom_range(1, 7), $urandom_range(1, 7), 1'($urandom_range(1)),
                $urandom_range(20, 60), $urandom_range(5, 12));
    end

    repeat (50) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/lge_pkg.sv
src/life_generation_engine.sv
src/lge_checker.sv
sim/tb_life_generation_engine.sv
